### sv/button_short_long_press_detector_macros.svh
// Assertion macros for the checker file of the press detector.
// No dependencies; include by bare file name.
`ifndef BUTTON_SHORT_LONG_PRESS_DETECTOR_MACROS_SVH
`define BUTTON_SHORT_LONG_PRESS_DETECTOR_MACROS_SVH

// same-cycle implication, gated by the active-low reset
`define BSLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, gated by the active-low reset
`define BSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/bslp_pkg.sv
// Package for the button short/long press detector: item types, op codes,
// register indexes and the configuration struct. No dependencies.
package bslp_pkg;

    localparam int REG_WIDTH  = 16;
    localparam int ADDR_WIDTH = 4;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_READ_SHORT = 2'd1,
        OP_READ_LONG  = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_SHORT_PRESS = 2'd0,
        REG_LONG_PRESS  = 2'd1,
        REG_RELEASE     = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [1:0] op;
        logic       pressed;
    } t_in;

    typedef struct packed {
        logic event_flag;
        logic busy_res;
    } t_out;

    typedef struct packed {
        logic [REG_WIDTH-1:0] short_press_ticks;
        logic [REG_WIDTH-1:0] long_press_ticks;
        logic [REG_WIDTH-1:0] release_ticks;
    } t_cfg;

endpackage

### sv/bslp_core.sv
// Press classifier state: held/released counters, busy, edge memory and
// sticky pending flags. Depends on bslp_pkg.
module bslp_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  bslp_pkg::t_in  i_item,
    input  bslp_pkg::t_cfg i_cfg,
    output bslp_pkg::t_out o_res
);

    // compare width covers both the counters and the 16-bit thresholds
    localparam int CMP_WIDTH = (COUNT_WIDTH > bslp_pkg::REG_WIDTH) ?
                               COUNT_WIDTH : bslp_pkg::REG_WIDTH;

    logic [COUNT_WIDTH-1:0] r_held, n_held;
    logic [COUNT_WIDTH-1:0] r_rel, n_rel;
    logic r_busy, n_busy;
    logic r_short_pend, n_short_pend;
    logic r_long_pend, n_long_pend;
    logic r_short_seen, n_short_seen;
    logic r_long_seen, n_long_seen;

    logic held_lt_long, held_ge_short, rel_lt_release;
    logic cond_short, cond_long, flag;

    assign held_lt_long   = CMP_WIDTH'(r_held) < CMP_WIDTH'(i_cfg.long_press_ticks);
    assign held_ge_short  = CMP_WIDTH'(r_held) >= CMP_WIDTH'(i_cfg.short_press_ticks);
    assign rel_lt_release = CMP_WIDTH'(r_rel) < CMP_WIDTH'(i_cfg.release_ticks);

    always_comb begin
        n_held       = r_held;
        n_rel        = r_rel;
        n_busy       = r_busy;
        n_short_pend = r_short_pend;
        n_long_pend  = r_long_pend;
        n_short_seen = r_short_seen;
        n_long_seen  = r_long_seen;
        cond_short   = 1'b0;
        cond_long    = 1'b0;
        flag         = 1'b0;
        if (i_take) begin
            case (i_item.op)
                bslp_pkg::OP_TICK: begin
                    if (i_item.pressed) begin
                        n_busy = 1'b1;
                        n_rel  = '0;
                        if (held_lt_long) begin
                            n_held = r_held + COUNT_WIDTH'(1);
                        end else begin
                            cond_long = 1'b1;
                        end
                    end else begin
                        cond_short = held_ge_short && held_lt_long;
                        n_held     = '0;
                        if (rel_lt_release) begin
                            n_rel = r_rel + COUNT_WIDTH'(1);
                        end else begin
                            n_busy = 1'b0;
                        end
                    end
                    // rising edge against the previous tick
                    if (cond_short && !r_short_seen) begin
                        n_short_pend = 1'b1;
                    end
                    if (cond_long && !r_long_seen) begin
                        n_long_pend = 1'b1;
                    end
                    n_short_seen = cond_short;
                    n_long_seen  = cond_long;
                end
                bslp_pkg::OP_READ_SHORT: begin
                    flag         = r_short_pend;
                    n_short_pend = 1'b0;
                end
                bslp_pkg::OP_READ_LONG: begin
                    flag        = r_long_pend;
                    n_long_pend = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res.event_flag = flag;
    assign o_res.busy_res   = n_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_rel        <= '0;
            r_busy       <= 1'b0;
            r_short_pend <= 1'b0;
            r_long_pend  <= 1'b0;
            r_short_seen <= 1'b0;
            r_long_seen  <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_rel        <= n_rel;
            r_busy       <= n_busy;
            r_short_pend <= n_short_pend;
            r_long_pend  <= n_long_pend;
            r_short_seen <= n_short_seen;
            r_long_seen  <= n_long_seen;
        end
    end

endmodule

### sv/button_short_long_press_detector.sv
// Top level of the button short/long press detector: APB register file,
// item handshake and result register. Depends on bslp_pkg and bslp_core.
//
//  channel  | signals                               | item / width
//  ---------+---------------------------------------+---------------------------
//  input    | i_in_valid, o_in_ready, i_in          | t_in: op 2b, pressed 1b
//  result   | o_out_valid, i_out_ready, o_out       | t_out: event_flag, busy_res
//  config   | psel penable pwrite paddr pwdata ...  | three 16-bit registers
//
// One item per cycle unless stalled: an accepted item updates the classifier state at the
// accepting edge, and its result is loaded into the result register at that same edge.
// The single result register is refilled in the same cycle it is drained, so
// the input only stalls while a result waits and i_out_ready is low.
// Reset (synchronous, i_rst_n low) clears counters, flags, registers and
// the result valid bit; there is no clearing sweep.
module button_short_long_press_detector #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bslp_pkg::t_in                     i_in,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bslp_pkg::t_out                    o_out,
    // APB register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bslp_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    bslp_pkg::t_cfg   r_cfg;
    bslp_pkg::t_reg_idx reg_idx;
    bslp_pkg::t_out   core_res;
    bslp_pkg::t_out   r_out;
    logic             r_out_valid;
    logic             take;
    logic             cfg_wr;

    // registers sit at word addresses; the low two address bits are ignored
    assign reg_idx = bslp_pkg::t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (reg_idx)
            bslp_pkg::REG_SHORT_PRESS: prdata = 32'(r_cfg.short_press_ticks);
            bslp_pkg::REG_LONG_PRESS:  prdata = 32'(r_cfg.long_press_ticks);
            bslp_pkg::REG_RELEASE:     prdata = 32'(r_cfg.release_ticks);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                bslp_pkg::REG_SHORT_PRESS: begin
                    r_cfg.short_press_ticks <= pwdata[bslp_pkg::REG_WIDTH-1:0];
                end
                bslp_pkg::REG_LONG_PRESS: begin
                    r_cfg.long_press_ticks <= pwdata[bslp_pkg::REG_WIDTH-1:0];
                end
                bslp_pkg::REG_RELEASE: begin
                    r_cfg.release_ticks <= pwdata[bslp_pkg::REG_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // accept when the result slot is empty or being drained this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    bslp_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### sv/bslp_chk.sv
// Port-level checker for the press detector, bound to the top level.
// Depends on bslp_pkg and the shared assertion macro header.
`include "button_short_long_press_detector_macros.svh"

module bslp_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input bslp_pkg::t_in                     i_in,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input bslp_pkg::t_out                    o_out
);

    logic take;
    logic take_tick;
    logic take_held;

    assign take      = i_in_valid && o_in_ready;
    assign take_tick = take && (i_in.op == bslp_pkg::OP_TICK);
    assign take_held = take_tick && i_in.pressed;

    // every accepted item shows its result in the next cycle
    `BSLP_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, take, o_out_valid)
    // a held tick always leaves the block busy
    `BSLP_ASSERT_NEXT(a_held_busy, i_clk, i_rst_n, take_held, o_out.busy_res)
    // ticks never return a pending flag
    `BSLP_ASSERT_NEXT(a_tick_no_flag, i_clk, i_rst_n, take_tick, !o_out.event_flag)
    // a waiting result holds still
    `BSLP_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                      o_out_valid && $stable(o_out))

endmodule

bind button_short_long_press_detector bslp_chk u_bslp_chk (.*);
